FILE: rtl/core/uhm_pkg.sv
// Package for the usage hour meter: widths, counter limits, beat payload types
// and the shared minute/second step function.
// Depends on nothing; every other file of the block imports it.
package uhm_pkg;

  // Width of the hour counters and of the hour fields on the result channel.
  localparam int unsigned HOUR_BITS     = 16;
  localparam int unsigned HOUR_OUT_BITS = 16;

  // Seconds per minute and minutes per hour, and the width of those counters.
  localparam int unsigned UNITS_PER_NEXT = 60;
  localparam int unsigned CNT_BITS       = 6;

  // Mode counters, in result order.
  localparam int unsigned MODE_COUNT     = 6;
  localparam int unsigned MODE_BRUSH     = 0;
  localparam int unsigned MODE_VACUUM    = 1;
  localparam int unsigned MODE_PRESWEEP  = 2;
  localparam int unsigned MODE_ECO       = 3;
  localparam int unsigned MODE_WATER     = 4;
  localparam int unsigned MODE_DETERGENT = 5;

  typedef logic [HOUR_BITS-1:0]     hour_t;
  typedef logic [HOUR_OUT_BITS-1:0] hour_out_t;
  typedef logic [CNT_BITS-1:0]      cnt_t;

  // One step of a wrapping seconds or minutes counter.
  typedef struct packed {
    logic wrap;
    cnt_t next;
  } cnt_step_t;

  // Input beat: one second tick with the machine status.
  typedef struct packed {
    logic runtime_enable;
    logic brush_on;
    logic vacuum_on;
    logic presweep_on;
    logic eco_on;
    logic water_pump_on;
    logic detergent_pump_on;
  } uhm_in_t;

  // Result beat: hour counts after this tick, plus event flags.
  typedef struct packed {
    hour_out_t total_hours;
    hour_out_t brush_hours_out;
    hour_out_t vacuum_hours_out;
    hour_out_t presweep_hours_out;
    hour_out_t eco_hours_out;
    hour_out_t water_hours_out;
    hour_out_t detergent_hours_out;
    logic      minute_event;
    logic      counting;
  } uhm_out_t;

  // Advance a counter by one; it wraps to zero when it reaches the limit.
  function automatic cnt_step_t cnt_step(cnt_t cur);
    cnt_step_t res;
    cnt_t      inc;
    inc      = cur + cnt_t'(1);
    res.wrap = (inc >= cnt_t'(UNITS_PER_NEXT));
    res.next = res.wrap ? '0 : inc;
    return res;
  endfunction

  // The hour fields carry the low bits of the count, zero-extended if narrower.
  function automatic hour_out_t hour_field(hour_t h);
    logic [HOUR_BITS+HOUR_OUT_BITS-1:0] wide;
    wide = {{HOUR_OUT_BITS{1'b0}}, h};
    return wide[HOUR_OUT_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/uhm_if.sv
// Valid/ready channel interfaces of the usage hour meter.
// Depends on uhm_pkg for the beat payload types.
interface uhm_in_if
  import uhm_pkg::*;
  ;
  logic    valid;
  logic    ready;
  uhm_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface uhm_out_if
  import uhm_pkg::*;
  ;
  logic     valid;
  logic     ready;
  uhm_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/uhm_tick.sv
// Seconds counter of the usage hour meter: flags the tick that completes a minute.
// Depends on uhm_pkg for the counter width and step function.
module uhm_tick
  import uhm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic run_i,
  output logic minute_o
);

  cnt_t      sec_r;
  cnt_t      sec_nxt;
  cnt_step_t step;

  // Count counted ticks; the wrap is the minute pulse.
  always_comb begin
    step     = cnt_step(sec_r);
    sec_nxt  = run_i ? step.next : sec_r;
    minute_o = run_i && step.wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r <= '0;
    end else begin
      sec_r <= sec_nxt;
    end
  end

endmodule

FILE: rtl/core/uhm_pair.sv
// One minute/hour counter pair with a saturating hour count.
// Depends on uhm_pkg for widths and the step function.
module uhm_pair
  import uhm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  bump_i,
  output hour_t hours_nxt_o
);

  cnt_t      min_r;
  cnt_t      min_nxt;
  hour_t     hour_r;
  hour_t     hour_nxt;
  cnt_step_t step;

  // Add one minute; on the minute wrap add an hour unless already at maximum.
  always_comb begin
    step     = cnt_step(min_r);
    min_nxt  = min_r;
    hour_nxt = hour_r;
    if (bump_i) begin
      min_nxt = step.next;
      if (step.wrap && (hour_r != '1)) begin
        hour_nxt = hour_r + hour_t'(1);
      end
    end
    hours_nxt_o = hour_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      hour_r <= '0;
    end else begin
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
    end
  end

endmodule

FILE: rtl/core/usage_hour_meter_top.sv
// Usage hour meter top level: input register, counter update, result register.
// A beat accepted into the input register is loaded into the result register
// once the result register is free or its beat is being taken.
// Throughput: one beat per cycle unless the output stalls; the counters update in
// the same cycle the beat moves from the input register to the result register.
// Reset (synchronous, active low) clears all counters and both valid flags.
module usage_hour_meter_top
  import uhm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  uhm_in_if.sink    in_ch,
  uhm_out_if.source out_ch
);

  logic     s1_valid_r;
  logic     s1_valid_nxt;
  uhm_in_t  s1_data_r;
  logic     out_valid_r;
  logic     out_valid_nxt;
  uhm_out_t out_data_r;
  uhm_out_t out_data_nxt;

  logic                  adv;
  logic                  run;
  logic                  minute;
  logic [MODE_COUNT-1:0] cond;
  hour_t                 total_nxt;
  hour_t                 mode_nxt [MODE_COUNT];

  // Handshake: the input register moves on whenever the result register is free.
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign s1_valid_nxt = (in_ch.valid && in_ch.ready) || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // A tick counts only while it advances and the run timer is enabled.
  assign run = adv && s1_data_r.runtime_enable;

  // Mode conditions; water and detergent count only with the brush running.
  always_comb begin
    cond                 = '0;
    cond[MODE_BRUSH]     = s1_data_r.brush_on;
    cond[MODE_VACUUM]    = s1_data_r.vacuum_on;
    cond[MODE_PRESWEEP]  = s1_data_r.presweep_on;
    cond[MODE_ECO]       = s1_data_r.eco_on;
    cond[MODE_WATER]     = s1_data_r.water_pump_on && s1_data_r.brush_on;
    cond[MODE_DETERGENT] = s1_data_r.detergent_pump_on && s1_data_r.brush_on;
  end

  uhm_tick u_tick (
    .clk      (clk),
    .rst_n    (rst_n),
    .run_i    (run),
    .minute_o (minute)
  );

  uhm_pair u_total (
    .clk         (clk),
    .rst_n       (rst_n),
    .bump_i      (minute),
    .hours_nxt_o (total_nxt)
  );

  for (genvar k = 0; k < MODE_COUNT; k++) begin : g_mode
    uhm_pair u_mode (
      .clk         (clk),
      .rst_n       (rst_n),
      .bump_i      (minute && cond[k]),
      .hours_nxt_o (mode_nxt[k])
    );
  end

  // Result beat from the updated counts.
  always_comb begin
    out_data_nxt.total_hours         = hour_field(total_nxt);
    out_data_nxt.brush_hours_out     = hour_field(mode_nxt[MODE_BRUSH]);
    out_data_nxt.vacuum_hours_out    = hour_field(mode_nxt[MODE_VACUUM]);
    out_data_nxt.presweep_hours_out  = hour_field(mode_nxt[MODE_PRESWEEP]);
    out_data_nxt.eco_hours_out       = hour_field(mode_nxt[MODE_ECO]);
    out_data_nxt.water_hours_out     = hour_field(mode_nxt[MODE_WATER]);
    out_data_nxt.detergent_hours_out = hour_field(mode_nxt[MODE_DETERGENT]);
    out_data_nxt.minute_event        = minute;
    out_data_nxt.counting            = s1_data_r.runtime_enable;
  end

  // Valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_data_r <= in_ch.data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  // A completed minute is only ever reported on a counted tick.
  a_minute_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (!out_ch.data.minute_event || out_ch.data.counting))
    else $error("minute_event raised on a tick that was not counted");

  // The seconds counter only wraps on an advancing, enabled beat.
  a_minute_source: assert property (@(posedge clk) disable iff (!rst_n)
    minute |-> (adv && s1_data_r.runtime_enable))
    else $error("minute pulse without an advancing counted beat");

  // Input stalls only when both the input and result registers are held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");
`endif

endmodule
